// File: sv/bre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bre_pkg
// Shared types and constants of the battery runtime estimator.
// ---------------------------------------------------------------------------
package bre_pkg;
	localparam int DEPTH_DEF = 64;
	localparam int FRAC_DEF = 16;
	localparam logic [6:0] WINDOW_RESET = 7'd50;
	localparam logic [7:0] LEVEL_UNKNOWN = 8'd255;
	localparam logic [6:0] LEVEL_MAX = 7'd100;

	// request handed from the front to the back
	typedef struct packed {
		logic       recorded;
		logic [6:0] level;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_READ, BK_PAIR, BK_DIV, BK_AVG, BK_MUL, BK_DONE
	} bk_state_t;
endpackage
`default_nettype wire

// File: sv/bre_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bre_front
// Classifies samples, updates the history ring and hands a request onward.
// ---------------------------------------------------------------------------
module bre_front #(
	parameter int DEPTH = bre_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [6:0]          window_points,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                charging,
	input  wire logic [7:0]          percent,
	input  wire logic [31:0]         timestamp_s,
	output logic                     job_valid,
	input  wire logic                job_stall,
	output bre_pkg::job_t            job,
	output logic [AW-1:0]            oldest,
	output logic [CW-1:0]            count,
	input  wire logic [AW-1:0]       rd_addr,
	output logic [31:0]              rd_time,
	output logic [6:0]               rd_level
);
	import bre_pkg::*;

	logic [31:0] time_mem [DEPTH];
	logic [6:0]  level_mem [DEPTH];
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] count_q;
	logic [7:0]    last_q;
	logic          full_q;
	job_t          job_q;

	logic          take;
	logic [6:0]    pct;
	logic [CW-1:0] cnt0, cnt1, weff;
	logic [AW-1:0] old1, pos;
	logic          acc;

	// ring index from a sum below twice the depth
	function automatic logic [AW-1:0] wrap_idx(input int unsigned x);
		return (x >= DEPTH) ? AW'(x - DEPTH) : AW'(x);
	endfunction

	assign in_stall = full_q;
	assign acc = in_valid && !full_q;
	assign pct = (percent > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : percent[6:0];

	always_comb begin
		weff = (window_points < 7'd2) ? CW'(2) :
			((32'(window_points) > DEPTH) ? CW'(DEPTH) : CW'(window_points));
		take = 1'b0;
		cnt0 = count_q;
		if (charging) begin
			cnt0 = '0;
		end else if (percent != LEVEL_UNKNOWN) begin
			take = 1'b1;
			if (last_q != LEVEL_UNKNOWN) begin
				if ({1'b0, pct} == last_q) take = 1'b0;
				else if ({1'b0, pct} > last_q) cnt0 = '0;
			end
		end
		old1 = oldest_q;
		cnt1 = cnt0;
		pos = wrap_idx(32'(oldest_q) + 32'(cnt0));
		if (take) begin
			if (32'(cnt0) >= DEPTH) begin
				pos = oldest_q;
				old1 = wrap_idx(32'(oldest_q) + 32'd1);
			end else begin
				cnt1 = cnt0 + CW'(1);
			end
			// window holds at most one extra after appending, unless shrunk
			if (cnt1 > weff) begin
				old1 = wrap_idx(32'(old1) + 32'(cnt1) - 32'(weff));
				cnt1 = weff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && take) begin
			time_mem[pos] <= timestamp_s;
			level_mem[pos] <= pct;
		end
		rd_time <= time_mem[rd_addr];
		rd_level <= level_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q <= '0;
			last_q <= LEVEL_UNKNOWN;
			full_q <= 1'b0;
			job_q <= '0;
		end else begin
			if (acc) begin
				oldest_q <= old1;
				count_q <= cnt1;
				if (take) last_q <= {1'b0, pct};
				job_q.recorded <= take;
				job_q.level <= take ? pct : last_q[6:0];
				full_q <= 1'b1;
			end else if (full_q && !job_stall) begin
				full_q <= 1'b0;
			end
		end
	end

	assign job_valid = full_q;
	assign job = job_q;
	assign oldest = oldest_q;
	assign count = count_q;
endmodule
`default_nettype wire

// File: sv/bre_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bre_back
// Walks adjacent pairs with a serial divider, averages and scales.
// ---------------------------------------------------------------------------
module bre_back #(
	parameter int DEPTH = bre_pkg::DEPTH_DEF,
	parameter int FRAC = bre_pkg::FRAC_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_stall,
	input  wire bre_pkg::job_t job,
	input  wire logic [AW-1:0] oldest,
	input  wire logic [CW-1:0] count,
	output logic [AW-1:0]      rd_addr,
	input  wire logic [31:0]   rd_time,
	input  wire logic [6:0]    rd_level,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [31:0]        remaining_s,
	output logic [6:0]         points_held,
	output logic               recorded
);
	import bre_pkg::*;

	localparam int DW = 64;

	bk_state_t state_q, state_d;
	logic [CW-1:0] k_q;
	logic [31:0]   ta_q;
	logic [6:0]    la_q;
	logic          first_q;
	logic [DW-1:0] num_q, quo_q, sum_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [6:0]    bit_q;
	logic          avg_q;
	logic [6:0]    lvl_q;
	logic [71:0]   prod_q;
	logic          rec_q;
	logic [6:0]    held_q;
	logic [31:0]   res_out_q;
	logic [6:0]    held_out_q;
	logic          rec_out_q;

	logic [DW:0]   rem_sh;
	logic          out_busy, finish, last_pair, walk_done;
	logic [31:0]   res_d;
	logic [DW-1:0] ratio_fin;
	logic [DW:0]   sum_fin;

	// ring index from a sum below twice the depth
	function automatic logic [AW-1:0] wrap_idx(input int unsigned x);
		return (x >= DEPTH) ? AW'(x - DEPTH) : AW'(x);
	endfunction

	assign out_busy = out_valid && out_stall;
	assign finish = (state_q == BK_DONE) && !out_busy;
	// request stays in the front until its result leaves, so the ring holds still
	assign job_stall = !finish;
	assign rd_addr = wrap_idx(32'(oldest) + 32'(k_q));
	assign rem_sh = {rem_q[DW-1:0], num_q[DW-1]};
	assign last_pair = (32'(k_q) + 1 >= 32'(count));
	assign walk_done = (32'(k_q) >= 32'(count));
	assign res_d = (count < CW'(2)) ? '0 :
		((|prod_q[71:32+FRAC]) ? 32'hFFFF_FFFF : prod_q[32+FRAC-1:FRAC]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (job_valid) state_d = (count < CW'(2)) ? BK_DONE : BK_READ;
			BK_READ: state_d = BK_PAIR;
			BK_PAIR: begin
				if (first_q) state_d = BK_READ;
				else if (ta_q <= rd_time && la_q > rd_level) state_d = BK_DIV;
				else state_d = last_pair ? BK_AVG : BK_READ;
			end
			BK_DIV: if (bit_q == 7'd0) state_d = avg_q ? BK_MUL : (walk_done ? BK_AVG : BK_READ);
			BK_AVG: state_d = BK_DIV;
			BK_MUL: state_d = BK_DONE;
			BK_DONE: if (!out_busy) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_out_q <= res_d;
			held_out_q <= held_q;
			rec_out_q <= rec_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				k_q <= '0;
				first_q <= 1'b1;
				avg_q <= 1'b0;
				rec_q <= job.recorded;
				lvl_q <= job.level;
				held_q <= 7'(count);
			end
			BK_READ: ;
			BK_PAIR: begin
				ta_q <= rd_time;
				la_q <= rd_level;
				first_q <= 1'b0;
				if (!first_q && ta_q <= rd_time && la_q > rd_level) begin
					num_q <= DW'(rd_time - ta_q) << FRAC;
					den_q <= DW'(la_q - rd_level);
					rem_q <= '0;
					bit_q <= 7'(DW - 1);
				end
				k_q <= k_q + CW'(1);
			end
			BK_DIV: begin
				// restoring division, one quotient bit per cycle
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sh - {1'b0, den_q};
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
				num_q <= num_q << 1;
				bit_q <= bit_q - 7'd1;
			end
			BK_AVG: begin
				num_q <= sum_q;
				den_q <= DW'(count - CW'(1));
				rem_q <= '0;
				bit_q <= 7'(DW - 1);
				avg_q <= 1'b1;
			end
			BK_MUL: begin
				prod_q <= 72'(quo_q) * 72'(lvl_q);
			end
			BK_DONE: ;
			default: ;
		endcase
	end

	// accumulate the just finished ratio with saturation
	assign ratio_fin = {quo_q[DW-2:0], (rem_sh >= {1'b0, den_q})};
	assign sum_fin = {1'b0, sum_q} + {1'b0, ratio_fin};
	always_ff @(posedge clk) begin
		if (state_q == BK_DIV && bit_q == 7'd0 && !avg_q)
			sum_q <= sum_fin[DW] ? {DW{1'b1}} : sum_fin[DW-1:0];
		else if (state_q == BK_IDLE)
			sum_q <= '0;
	end

	assign remaining_s = res_out_q;
	assign points_held = held_out_q;
	assign recorded = rec_out_q;
endmodule
`default_nettype wire

// File: sv/battery_runtime_estimator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// battery_runtime_estimator_unit
// Keeps a window of discharge samples and estimates remaining runtime.
// ---------------------------------------------------------------------------
// channel  | handshake              | payload
// in       | in_valid / in_stall    | charging, percent, timestamp_s
// out      | out_valid / out_stall  | remaining_s, points_held, recorded
// cfg      | window_points_we       | window_points_wdata
// From accept to result, the back end reads adjacent pairs in turn and passes
// each falling pair through the serial 64-bit divider, then averages the
// ratios and scales them by the level. With fewer than two points it skips this.
// Reset clears counters and control; the sample memories are not cleared.
// The front holds a request until its result leaves the back end, so a
// stalled output stalls the input; the next request is taken in the cycle after.
// ---------------------------------------------------------------------------
module battery_runtime_estimator_unit #(
	parameter int HISTORY_DEPTH = bre_pkg::DEPTH_DEF,
	parameter int FRACTION_BITS = bre_pkg::FRAC_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        window_points_we,
	input  wire logic [6:0]  window_points_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        charging,
	input  wire logic [7:0]  percent,
	input  wire logic [31:0] timestamp_s,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      remaining_s,
	output logic [6:0]       points_held,
	output logic             recorded
);
	import bre_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	logic [6:0]    window_q;
	logic          job_valid, job_stall;
	job_t          job;
	logic [AW-1:0] oldest, rd_addr;
	logic [CW-1:0] count;
	logic [31:0]   rd_time;
	logic [6:0]    rd_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) window_q <= WINDOW_RESET;
		else if (window_points_we) window_q <= window_points_wdata;
	end

	bre_front #(.DEPTH(HISTORY_DEPTH)) u_front (
		.clk, .arst_n, .window_points(window_q),
		.in_valid, .in_stall, .charging, .percent, .timestamp_s,
		.job_valid, .job_stall, .job, .oldest, .count,
		.rd_addr, .rd_time, .rd_level
	);

	bre_back #(.DEPTH(HISTORY_DEPTH), .FRAC(FRACTION_BITS)) u_back (
		.clk, .arst_n, .job_valid, .job_stall, .job, .oldest, .count,
		.rd_addr, .rd_time, .rd_level,
		.out_valid, .out_stall, .remaining_s, .points_held, .recorded
	);
endmodule
`default_nettype wire
